@@ src/kmtr_pkg.sv @@
// ----------------------------------------------------------------------------
// kmtr_pkg
// Shared types, constants and helpers of the killer move table reorder unit.
// ----------------------------------------------------------------------------
package kmtr_pkg;

  // Default sizes
  localparam int MAX_PLIES_DEF = 128;
  localparam int LIST_SIZE_DEF = 64;

  // List position width: holds start_pos + 1 and the full list count
  localparam int POS_W = 7;

  // Request codes
  localparam logic [1:0] MODE_SAVE    = 2'd0;
  localparam logic [1:0] MODE_APPEND  = 2'd1;
  localparam logic [1:0] MODE_REORDER = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [6:0]         ply;
    logic [31:0]        move_word;
    logic signed [31:0] order_score;
    logic [5:0]         start_pos;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        out_move;
    logic signed [31:0] out_score;
    logic [5:0]         out_index;
    logic               out_last;
  } out_item_t;

  // Map a position of a rotated list back to the list before the rotation.
  // The rotation pulled entry j to pos and shifted pos..j-1 up by one.
  function automatic logic [POS_W-1:0] rot_map(input logic [POS_W-1:0] p,
                                               input logic [POS_W-1:0] pos,
                                               input logic [POS_W-1:0] j,
                                               input logic             found);
    logic [POS_W-1:0] r;
    r = p;
    if (found && (p == pos)) begin
      r = j;
    end else if (found && (p > pos) && (p <= j)) begin
      r = p - POS_W'(1);
    end
    return r;
  endfunction

endpackage

@@ src/killer_move_table_reorder_unit.sv @@
// ----------------------------------------------------------------------------
// killer_move_table_reorder_unit
// Two-slot killer move table per ply plus a move list that is reordered so
// the killers come first at a given position, then streamed out.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one request (mode, ply, move, score,
//   start position). out_valid/out_ready/out_data carry reordered list
//   entries, one per transfer, with out_last on the final entry.
//   Save passes through a write-back state; append and clear finish on
//   acceptance. In a reorder, both killer searches and the emission share
//   the single read port of the list RAM, one entry per cycle while the
//   receiver keeps up. A search stops early on a hit, and at once when it
//   starts at or past the end. An empty list emits nothing.
//   A new request is accepted once the last entry sits in the output
//   register; it need not have been taken yet.
//   Killer slots start out zero after reset and after a clear request: a
//   per-ply valid bit masks the killer RAM, so neither needs a sweep.
//   When the receiver stalls, emission holds with one entry in the output
//   register and one waiting at the RAM output, and resumes without loss.
// ----------------------------------------------------------------------------
module killer_move_table_reorder_unit
  import kmtr_pkg::*;
#(
  parameter int MAX_PLIES = MAX_PLIES_DEF,
  parameter int LIST_SIZE = LIST_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int PLY_AW = $clog2(MAX_PLIES);
  localparam int PLY_EW = (PLY_AW > 7) ? PLY_AW : 7;
  localparam int LIST_AW = $clog2(LIST_SIZE);
  localparam int CNT_W = $clog2(LIST_SIZE + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SAVE = 3'd1;
  localparam logic [2:0] S_KEYS = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]           state_r, state_nxt;
  in_item_t             item_r, item_nxt;
  logic [MAX_PLIES-1:0] kv_r, kv_nxt;
  logic                 kvld_r, kvld_nxt;
  logic                 ply_ok_r, ply_ok_nxt;
  logic [31:0]          key1_r, key1_nxt, key2_r, key2_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 phase_r, phase_nxt;
  logic [POS_W-1:0]     q_r, q_nxt, c_r, c_nxt;
  logic                 cv_r, cv_nxt;
  logic [POS_W-1:0]     j1_r, j1_nxt, j2_r, j2_nxt;
  logic                 f1_r, f1_nxt, f2_r, f2_nxt;
  logic                 pv_r, pv_nxt;
  logic [POS_W-1:0]     pe_r, pe_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 in_xfer;
  logic [PLY_EW-1:0]    ply_ext;
  logic [PLY_AW-1:0]    ply_addr;
  logic [PLY_EW-1:0]    ply_ext_r;
  logic [PLY_AW-1:0]    k_waddr;
  logic                 ply_ok;
  logic [POS_W-1:0]     count_pos, start_pos1, start_pos2;
  logic [31:0]          first_old, key_cur;
  logic                 hit, s_issue, s_done, e_issue, load;
  logic [POS_W-1:0]     s_addr, e_addr;

  // Killer RAM: {first, second} per ply
  logic                 k_we, k_re;
  logic [63:0]          k_wdata, k_rdata;
  // List RAM: {move, score} per position
  logic                 l_we, l_re;
  logic [LIST_AW-1:0]   l_raddr;
  logic [63:0]          l_rdata;

  kmtr_ram #(.WIDTH(64), .DEPTH(MAX_PLIES)) u_killer_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .re    (k_re),
    .raddr (ply_addr),
    .rdata (k_rdata)
  );

  kmtr_ram #(.WIDTH(64), .DEPTH(LIST_SIZE)) u_list_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (LIST_AW'(count_r)),
    .wdata ({in_data.move_word, in_data.order_score}),
    .re    (l_re),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  // Decode the incoming request
  assign in_ready   = (state_r == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign ply_ext    = PLY_EW'(in_data.ply);
  assign ply_addr   = ply_ext[PLY_AW-1:0];
  assign ply_ok     = {1'b0, ply_ext} < (PLY_EW + 1)'(MAX_PLIES);
  assign count_pos  = POS_W'(count_r);
  assign start_pos1 = POS_W'(item_r.start_pos);
  assign start_pos2 = start_pos1 + POS_W'(1);

  // Address bits of the registered ply, widened when the table is deeper
  assign ply_ext_r  = PLY_EW'(item_r.ply);
  assign k_waddr    = ply_ext_r[PLY_AW-1:0];

  // Killer RAM access: read on save and reorder, write back on save
  assign k_re      = in_xfer && ((in_data.mode == MODE_SAVE) ||
                                 (in_data.mode == MODE_REORDER));
  assign first_old = kvld_r ? k_rdata[63:32] : 32'd0;
  assign k_we      = (state_r == S_SAVE) && ply_ok_r &&
                     (first_old != item_r.move_word);
  assign k_wdata   = {item_r.move_word, first_old};

  // Search: one list entry read per cycle, compared at the registered RAM output
  assign key_cur = phase_r ? key2_r : key1_r;
  assign hit     = cv_r && (l_rdata[63:32] == key_cur);
  assign s_issue = (state_r == S_SRCH) && ply_ok_r && (q_r < count_pos);
  assign s_done  = hit || (!cv_r && !s_issue);
  assign s_addr  = phase_r ? rot_map(q_r, start_pos1, j1_r, f1_r) : q_r;

  // Emit: map through both rotations, keep a two-deep buffer toward out
  assign load    = pv_r && (!out_valid_r || out_ready);
  assign e_issue = (state_r == S_EMIT) && (q_r < count_pos) && (!pv_r || load);
  assign e_addr  = rot_map(rot_map(q_r, start_pos2, j2_r, f2_r),
                           start_pos1, j1_r, f1_r);

  assign l_we    = in_xfer && (in_data.mode == MODE_APPEND) &&
                   (count_pos < POS_W'(LIST_SIZE));
  assign l_re    = s_issue || e_issue;
  assign l_raddr = (state_r == S_SRCH) ? LIST_AW'(s_addr) : LIST_AW'(e_addr);

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    kv_nxt        = kv_r;
    kvld_nxt      = kvld_r;
    ply_ok_nxt    = ply_ok_r;
    key1_nxt      = key1_r;
    key2_nxt      = key2_r;
    count_nxt     = count_r;
    phase_nxt     = phase_r;
    q_nxt         = q_r;
    c_nxt         = c_r;
    cv_nxt        = cv_r;
    j1_nxt        = j1_r;
    j2_nxt        = j2_r;
    f1_nxt        = f1_r;
    f2_nxt        = f2_r;
    pv_nxt        = pv_r;
    pe_nxt        = pe_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          item_nxt   = in_data;
          ply_ok_nxt = ply_ok;
          kvld_nxt   = kv_r[ply_addr];
          case (in_data.mode)
            MODE_SAVE:    state_nxt = S_SAVE;
            MODE_APPEND: begin
              if (l_we) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            MODE_REORDER: state_nxt = S_KEYS;
            MODE_CLEAR:   kv_nxt = '0;
            default:      state_nxt = S_IDLE;
          endcase
        end
      end
      S_SAVE: begin
        if (k_we) begin
          kv_nxt[k_waddr] = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_KEYS: begin
        key1_nxt  = kvld_r ? k_rdata[63:32] : 32'd0;
        key2_nxt  = kvld_r ? k_rdata[31:0] : 32'd0;
        phase_nxt = 1'b0;
        q_nxt     = start_pos1;
        cv_nxt    = 1'b0;
        state_nxt = S_SRCH;
      end
      S_SRCH: begin
        if (s_done) begin
          cv_nxt = 1'b0;
          if (!phase_r) begin
            j1_nxt    = c_r;
            f1_nxt    = hit;
            phase_nxt = 1'b1;
            q_nxt     = start_pos2;
          end else begin
            j2_nxt    = c_r;
            f2_nxt    = hit;
            q_nxt     = '0;
            pv_nxt    = 1'b0;
            state_nxt = S_EMIT;
          end
        end else begin
          cv_nxt = s_issue;
          c_nxt  = q_r;
          q_nxt  = q_r + POS_W'(s_issue);
        end
      end
      S_EMIT: begin
        if (e_issue) begin
          pv_nxt = 1'b1;
          pe_nxt = q_r;
          q_nxt  = q_r + POS_W'(1);
        end else if (load) begin
          pv_nxt = 1'b0;
        end
        if ((q_r >= count_pos) && !pv_r) begin
          count_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Output register: load a pending entry, drop it on transfer
    if (load) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.out_move  = l_rdata[63:32];
      out_data_nxt.out_score = l_rdata[31:0];
      out_data_nxt.out_index = pe_r[5:0];
      out_data_nxt.out_last  = (pe_r + POS_W'(1)) == count_pos;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kv_r        <= '0;
      count_r     <= '0;
      cv_r        <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kv_r        <= kv_nxt;
      count_r     <= count_nxt;
      cv_r        <= cv_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    kvld_r     <= kvld_nxt;
    ply_ok_r   <= ply_ok_nxt;
    key1_r     <= key1_nxt;
    key2_r     <= key2_nxt;
    phase_r    <= phase_nxt;
    q_r        <= q_nxt;
    c_r        <= c_nxt;
    j1_r       <= j1_nxt;
    j2_r       <= j2_nxt;
    f1_r       <= f1_nxt;
    f2_r       <= f2_nxt;
    pe_r       <= pe_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_pos <= POS_W'(LIST_SIZE))
    else $error("list count above list size");

  a_pend_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == S_EMIT))
    else $error("pending list entry outside emission");

  a_killer_write: assert property (@(posedge clk) disable iff (!rst_n)
    k_we |-> ($past(state_r) == S_IDLE) && ply_ok_r)
    else $error("killer write without a preceding read");

  a_list_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    l_we |-> !l_re && (state_r == S_IDLE))
    else $error("list write overlaps a list read");

endmodule

@@ src/kmtr_ram.sv @@
// ----------------------------------------------------------------------------
// kmtr_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kmtr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register read data only when a read is requested
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
